/* hdl/g2e_pkg.sv */
`default_nettype none

package g2e_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 36;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ECC = 4'd1;

    // Field widths.
    localparam int AXIS_W = 33;
    localparam int ECC_W = 36;
    localparam int ANGLE_W = 32;
    localparam int LEN_W = 37;

    // Reset values of the ellipsoid registers (WGS-84).
    localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
    localparam logic [ECC_W-1:0] ECC_RESET = 36'd7360548650;

    // Q60 constants.
    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic [63:0] THREE_Q60 = 64'h3000_0000_0000_0000;
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Output saturation magnitude in millimeters.
    localparam logic [63:0] OUT_LIMIT = 64'd60000000000;

    // Horner denominators of the sine and cosine series.
    localparam int SIN_DEN [6] = '{156, 110, 72, 42, 20, 6};
    localparam int COS_DEN [7] = '{182, 132, 90, 56, 30, 12, 2};

endpackage

`default_nettype wire

/* hdl/geodetic_to_ecef_wgs84_unit.sv */
`default_nettype none

// Geodetic to ECEF converter. Latitude and longitude are binary angles (2^31 units per
// half turn), height and results are in millimeters; each coordinate saturates at
// +-60000000000. The datapath is a single pipeline of 33 chained 64-bit multiply stages
// (sine and cosine series, a Newton inverse square root, the radius and the final
// products), each split over two registers, plus an output register; a request passes
// through all of these registers before it shows up on out_valid, and one request can
// be accepted every clock unless the output stalls. The whole pipeline holds while a
// result waits on out_ready. The semi-major axis (index 0) and e squared in Q40
// (index 1) reset to WGS-84 and may only be written while no request is in flight.
module geodetic_to_ecef_wgs84_unit
    import g2e_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire signed [ANGLE_W-1:0]     latitude,
    input  wire signed [ANGLE_W-1:0]     longitude,
    input  wire signed [LEN_W-1:0]       height_mm,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [LEN_W-1:0]      pos_x_mm,
    output logic signed [LEN_W-1:0]      pos_y_mm,
    output logic signed [LEN_W-1:0]      pos_z_mm,
    input  wire                          cfg_we,
    input  wire [CFG_INDEX_W-1:0]        cfg_index,
    input  wire [CFG_DATA_W-1:0]         cfg_data
);

    typedef struct packed {
        logic [LEN_W-1:0] h;
        logic [63:0]      slm;
        logic             sln;
        logic [63:0]      clco;
        logic [63:0]      clso;
        logic             xneg;
        logic             yneg;
    } side_t;

    typedef struct packed {
        logic [63:0] w;
        side_t       sd;
    } ws_t;

    typedef struct packed {
        logic [63:0] w;
        logic [63:0] y;
        side_t       sd;
    } nr_t;

    typedef struct packed {
        logic [63:0] n;
        side_t       sd;
    } ns_t;

    logic [AXIS_W-1:0] axis_reg;
    logic [ECC_W-1:0]  ecc_reg;
    logic              en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_RESET;
            ecc_reg <= ECC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS: axis_reg <= cfg_data[AXIS_W-1:0];
                REG_ECC:  ecc_reg <= cfg_data[ECC_W-1:0];
                default:  ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless a result is held at the output.
    logic out_valid_reg;
    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Sine and cosine of both angles; the height rides along split over the two units.
    logic        lat_vld;
    logic        lon_vld;
    logic [63:0] slm;
    logic        sln;
    logic [63:0] clm;
    logic        cln;
    logic [63:0] som;
    logic        son;
    logic [63:0] com;
    logic        con;
    logic [18:0] h_hi;
    logic [17:0] h_lo;

    g2e_sincos #(.SW(19)) u_lat (
        .clk, .rst_n, .en,
        .vld_in(in_valid), .ang(latitude), .side_in(height_mm[36:18]),
        .vld_out(lat_vld), .sin_mag(slm), .sin_neg(sln), .cos_mag(clm), .cos_neg(cln),
        .side_out(h_hi)
    );

    g2e_sincos #(.SW(18)) u_lon (
        .clk, .rst_n, .en,
        .vld_in(in_valid), .ang(longitude), .side_in(height_mm[17:0]),
        .vld_out(lon_vld), .sin_mag(som), .sin_neg(son), .cos_mag(com), .cos_neg(con),
        .side_out(h_lo)
    );

    // Squared sine of latitude and the two direction cosine products.
    logic [63:0]  s2;
    logic [101:0] s2_sb;
    logic         s2_vld;
    logic [63:0]  clco;
    logic [1:0]   clco_sb;
    logic         clco_vld;
    logic [63:0]  clso;
    logic         clso_sb;
    logic         clso_vld;

    g2e_mul #(.SH(60), .RND(1'b1), .SW(102)) u_s2 (
        .clk, .rst_n, .en,
        .vld_in(lat_vld & lon_vld), .a(slm), .b(slm), .side_in({h_hi, h_lo, slm, sln}),
        .vld_out(s2_vld), .p(s2), .side_out(s2_sb)
    );

    g2e_mul #(.SH(60), .RND(1'b1), .SW(2)) u_clco (
        .clk, .rst_n, .en,
        .vld_in(lat_vld & lon_vld), .a(clm), .b(com), .side_in({cln, con}),
        .vld_out(clco_vld), .p(clco), .side_out(clco_sb)
    );

    g2e_mul #(.SH(60), .RND(1'b1), .SW(1)) u_clso (
        .clk, .rst_n, .en,
        .vld_in(lat_vld & lon_vld), .a(clm), .b(som), .side_in(son),
        .vld_out(clso_vld), .p(clso), .side_out(clso_sb)
    );

    side_t sd0;
    always_comb
    begin
        sd0.h = s2_sb[101:65];
        sd0.slm = s2_sb[64:1];
        sd0.sln = s2_sb[0];
        sd0.clco = clco;
        sd0.clso = clso;
        sd0.xneg = clco_sb[1] ^ clco_sb[0];
        sd0.yneg = clco_sb[1] ^ clso_sb;
    end

    // Radicand w = 1 - e2 sin^2 lat.
    logic [63:0] wm;
    side_t       wm_sd;
    logic        wm_vld;

    g2e_mul #(.SH(60), .RND(1'b1), .SW($bits(side_t))) u_wm (
        .clk, .rst_n, .en,
        .vld_in(s2_vld & clco_vld & clso_vld), .a({8'd0, ecc_reg, 20'd0}), .b(s2),
        .side_in(sd0),
        .vld_out(wm_vld), .p(wm), .side_out(wm_sd)
    );

    // Newton iterations for 1/sqrt(w), three multiply stages each.
    nr_t  nr [5];
    logic nr_vld [5];

    always_comb
    begin
        nr[0].w = ONE_Q60 - wm;
        nr[0].y = ONE_Q60 + {1'b0, wm[63:1]};
        nr[0].sd = wm_sd;
    end
    assign nr_vld[0] = wm_vld;

    for (genvar i = 0; i < 4; i++)
    begin : g_newton
        logic [63:0] y2;
        nr_t         n1;
        logic        v1;
        logic [63:0] wy2;
        nr_t         n2;
        logic        v2;
        logic [63:0] y_new;
        ws_t         n3;

        g2e_mul #(.SH(60), .RND(1'b1), .SW($bits(nr_t))) u_m1 (
            .clk, .rst_n, .en,
            .vld_in(nr_vld[i]), .a(nr[i].y), .b(nr[i].y), .side_in(nr[i]),
            .vld_out(v1), .p(y2), .side_out(n1)
        );

        g2e_mul #(.SH(60), .RND(1'b1), .SW($bits(nr_t))) u_m2 (
            .clk, .rst_n, .en,
            .vld_in(v1), .a(n1.w), .b(y2), .side_in(n1),
            .vld_out(v2), .p(wy2), .side_out(n2)
        );

        g2e_mul #(.SH(61), .RND(1'b1), .SW($bits(ws_t))) u_m3 (
            .clk, .rst_n, .en,
            .vld_in(v2), .a(n2.y), .b(THREE_Q60 - wy2), .side_in({n2.w, n2.sd}),
            .vld_out(nr_vld[i+1]), .p(y_new), .side_out(n3)
        );

        always_comb
        begin
            nr[i+1].w = n3.w;
            nr[i+1].y = y_new;
            nr[i+1].sd = n3.sd;
        end
    end

    // Prime-vertical radius N and its e2 share.
    logic [63:0] n_val;
    side_t       n_sd;
    logic        n_vld;
    logic [63:0] ne;
    ns_t         ne_sb;
    logic        ne_vld;

    g2e_mul #(.SH(40), .RND(1'b1), .SW($bits(side_t))) u_n (
        .clk, .rst_n, .en,
        .vld_in(nr_vld[4]), .a({31'd0, axis_reg}), .b(nr[4].y), .side_in(nr[4].sd),
        .vld_out(n_vld), .p(n_val), .side_out(n_sd)
    );

    g2e_mul #(.SH(40), .RND(1'b1), .SW($bits(ns_t))) u_ne (
        .clk, .rst_n, .en,
        .vld_in(n_vld), .a(n_val), .b({28'd0, ecc_reg}), .side_in({n_val, n_sd}),
        .vld_out(ne_vld), .p(ne), .side_out(ne_sb)
    );

    // Radii (N + h) and (N (1 - e2) + h) in Q20 millimeters, as magnitude and sign.
    logic [63:0] h_q20;
    logic [63:0] rxy;
    logic [63:0] rz;
    logic [63:0] rxy_mag;
    logic [63:0] rz_mag;

    always_comb
    begin
        h_q20 = {{(64 - LEN_W){ne_sb.sd.h[LEN_W-1]}}, ne_sb.sd.h} << 20;
        rxy = ne_sb.n + h_q20;
        rz = ne_sb.n - ne + h_q20;
        rxy_mag = rxy[63] ? 64'd0 - rxy : rxy;
        rz_mag = rz[63] ? 64'd0 - rz : rz;
    end

    // Final products.
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] pz;
    logic        nx;
    logic        ny;
    logic        nz;
    logic        vx;
    logic        vy;
    logic        vz;

    g2e_mul #(.SH(80), .RND(1'b1), .SW(1)) u_px (
        .clk, .rst_n, .en,
        .vld_in(ne_vld), .a(rxy_mag), .b(ne_sb.sd.clco), .side_in(ne_sb.sd.xneg ^ rxy[63]),
        .vld_out(vx), .p(px), .side_out(nx)
    );

    g2e_mul #(.SH(80), .RND(1'b1), .SW(1)) u_py (
        .clk, .rst_n, .en,
        .vld_in(ne_vld), .a(rxy_mag), .b(ne_sb.sd.clso), .side_in(ne_sb.sd.yneg ^ rxy[63]),
        .vld_out(vy), .p(py), .side_out(ny)
    );

    g2e_mul #(.SH(80), .RND(1'b1), .SW(1)) u_pz (
        .clk, .rst_n, .en,
        .vld_in(ne_vld), .a(rz_mag), .b(ne_sb.sd.slm), .side_in(ne_sb.sd.sln ^ rz[63]),
        .vld_out(vz), .p(pz), .side_out(nz)
    );

    // Saturate and apply the sign.
    logic [LEN_W-1:0] x_next;
    logic [LEN_W-1:0] y_next;
    logic [LEN_W-1:0] z_next;
    logic [63:0]      mx;
    logic [63:0]      my;
    logic [63:0]      mz;

    always_comb
    begin
        mx = (px > OUT_LIMIT) ? OUT_LIMIT : px;
        my = (py > OUT_LIMIT) ? OUT_LIMIT : py;
        mz = (pz > OUT_LIMIT) ? OUT_LIMIT : pz;
        x_next = nx ? LEN_W'(64'd0 - mx) : mx[LEN_W-1:0];
        y_next = ny ? LEN_W'(64'd0 - my) : my[LEN_W-1:0];
        z_next = nz ? LEN_W'(64'd0 - mz) : mz[LEN_W-1:0];
    end

    // Output register.
    logic [LEN_W-1:0] pos_x_reg;
    logic [LEN_W-1:0] pos_y_reg;
    logic [LEN_W-1:0] pos_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vx & vy & vz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg <= x_next;
            pos_y_reg <= y_next;
            pos_z_reg <= z_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x_mm = pos_x_reg;
    assign pos_y_mm = pos_y_reg;
    assign pos_z_mm = pos_z_reg;

endmodule

`default_nettype wire

/* hdl/g2e_mul.sv */
`default_nettype none

module g2e_mul #(
    parameter int SH = 60,
    parameter bit RND = 1'b1,
    parameter int SW = 1
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            en,
    input  wire            vld_in,
    input  wire [63:0]     a,
    input  wire [63:0]     b,
    input  wire [SW-1:0]   side_in,
    output logic           vld_out,
    output logic [63:0]    p,
    output logic [SW-1:0]  side_out
);

    localparam logic [127:0] RND_ADD = RND ? (128'd1 << (SH - 1)) : 128'd0;

    logic [63:0]   pp_ll_reg;
    logic [63:0]   pp_lh_reg;
    logic [63:0]   pp_hl_reg;
    logic [63:0]   pp_hh_reg;
    logic [SW-1:0] side1_reg;
    logic [SW-1:0] side2_reg;
    logic          vld1_reg;
    logic          vld2_reg;
    logic [63:0]   p_reg;
    logic [63:0]   p_next;
    logic [127:0]  sum;
    logic [191:0]  sum_ext;

    // Valid bits travel with the data and freeze on a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    // First stage: four 32 by 32 partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            pp_lh_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            pp_hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp_hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            side1_reg <= side_in;
        end
    end

    // Second stage: sum the partial products, round if RND is set, and shift.
    always_comb
    begin
        sum = {64'd0, pp_ll_reg} + {32'd0, pp_lh_reg, 32'd0} + {32'd0, pp_hl_reg, 32'd0}
            + {pp_hh_reg, 64'd0} + RND_ADD;
        sum_ext = {64'd0, sum};
        p_next = sum_ext[SH +: 64];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            side2_reg <= side1_reg;
        end
    end

    assign vld_out = vld2_reg;
    assign p = p_reg;
    assign side_out = side2_reg;

endmodule

`default_nettype wire

/* hdl/g2e_sincos.sv */
`default_nettype none

module g2e_sincos
    import g2e_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                vld_in,
    input  wire [ANGLE_W-1:0]  ang,
    input  wire [SW-1:0]       side_in,
    output logic               vld_out,
    output logic [63:0]        sin_mag,
    output logic               sin_neg,
    output logic [63:0]        cos_mag,
    output logic               cos_neg,
    output logic [SW-1:0]      side_out
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam int SSW = 67;
    localparam int CSW = 64 + SW;
    localparam int XSW = 67 + SW;
    localparam int FSW = 67 + SW;

    logic [29:0]    frac;
    logic           swap;
    logic [29:0]    red;
    logic [63:0]    x_val;
    logic [XSW-1:0] x_sb;
    logic           x_vld;
    logic [63:0]    x2_val;
    logic [XSW-1:0] x2_sb;
    logic           x2_vld;

    logic [63:0]    ts [7];
    logic [63:0]    tc [7];
    logic [SSW-1:0] ssb [7];
    logic [CSW-1:0] csb [7];
    logic           vs [7];
    logic           vc [7];

    // Reduce the angle to one octant.
    always_comb
    begin
        frac = ang[29:0];
        swap = frac > 30'h2000_0000;
        red = swap ? 30'(31'h4000_0000 - 31'(frac)) : frac;
    end

    // Binary angle to radians in Q60.
    g2e_mul #(.SH(31), .RND(1'b1), .SW(XSW)) u_rad (
        .clk, .rst_n, .en,
        .vld_in(vld_in), .a(64'(red)), .b(PI_Q60),
        .side_in({64'd0, ang[31:30], swap, side_in}),
        .vld_out(x_vld), .p(x_val), .side_out(x_sb)
    );

    g2e_mul #(.SH(60), .RND(1'b1), .SW(XSW)) u_sq (
        .clk, .rst_n, .en,
        .vld_in(x_vld), .a(x_val), .b(x_val),
        .side_in({x_val, x_sb[SW+2:0]}),
        .vld_out(x2_vld), .p(x2_val), .side_out(x2_sb)
    );

    // Sine chain carries x and the octant code; cosine chain carries x squared.
    assign ts[0] = ONE_Q60;
    assign tc[0] = ONE_Q60;
    assign ssb[0] = x2_sb[XSW-1:SW];
    assign csb[0] = {x2_val, x2_sb[SW-1:0]};
    assign vs[0] = x2_vld;
    assign vc[0] = x2_vld;

    // Horner steps, sine and cosine side by side.
    for (genvar k = 0; k < 6; k++)
    begin : g_step
        localparam int LS = $clog2(SIN_DEN[k]);
        localparam int LC = $clog2(COS_DEN[k]);
        localparam logic [127:0] MS_W = (128'd1 << (60 + LS)) / 128'(SIN_DEN[k]) + 128'd1;
        localparam logic [127:0] MC_W = (128'd1 << (60 + LC)) / 128'(COS_DEN[k]) + 128'd1;
        localparam logic [63:0] MS = MS_W[63:0];
        localparam logic [63:0] MC = MC_W[63:0];

        logic [63:0]    hs;
        logic [63:0]    hc;
        logic [63:0]    qs;
        logic [63:0]    qc;
        logic [SSW-1:0] hs_sb;
        logic [CSW-1:0] hc_sb;
        logic           hs_vld;
        logic           hc_vld;

        g2e_mul #(.SH(60), .RND(1'b1), .SW(SSW)) u_hs (
            .clk, .rst_n, .en,
            .vld_in(vs[k]), .a(csb[k][CSW-1 -: 64]), .b(ts[k]), .side_in(ssb[k]),
            .vld_out(hs_vld), .p(hs), .side_out(hs_sb)
        );

        g2e_mul #(.SH(60), .RND(1'b1), .SW(CSW)) u_hc (
            .clk, .rst_n, .en,
            .vld_in(vc[k]), .a(csb[k][CSW-1 -: 64]), .b(tc[k]), .side_in(csb[k]),
            .vld_out(hc_vld), .p(hc), .side_out(hc_sb)
        );

        // Division by the series denominator through its reciprocal.
        g2e_mul #(.SH(60 + LS), .RND(1'b0), .SW(SSW)) u_ds (
            .clk, .rst_n, .en,
            .vld_in(hs_vld), .a(hs), .b(MS), .side_in(hs_sb),
            .vld_out(vs[k+1]), .p(qs), .side_out(ssb[k+1])
        );

        g2e_mul #(.SH(60 + LC), .RND(1'b0), .SW(CSW)) u_dc (
            .clk, .rst_n, .en,
            .vld_in(hc_vld), .a(hc), .b(MC), .side_in(hc_sb),
            .vld_out(vc[k+1]), .p(qc), .side_out(csb[k+1])
        );

        assign ts[k+1] = ONE_Q60 - qs;
        assign tc[k+1] = ONE_Q60 - qc;
    end

    // Last step: sine takes its final product while cosine does its seventh term.
    localparam int LC6 = $clog2(COS_DEN[6]);
    localparam logic [127:0] MC6_W = (128'd1 << (60 + LC6)) / 128'(COS_DEN[6]) + 128'd1;
    localparam logic [63:0] MC6 = MC6_W[63:0];

    logic [63:0]    s_fin;
    logic [2:0]     s_code;
    logic           s_vld;
    logic [63:0]    hc6;
    logic [SW-1:0]  hc6_sb;
    logic           hc6_vld;
    logic [63:0]    qc6;
    logic [FSW-1:0] fin_sb;
    logic           fin_vld;
    logic [63:0]    sv;
    logic [63:0]    cv;
    logic [63:0]    o_sin;
    logic [63:0]    o_cos;
    logic [1:0]     quad;
    logic           oct_swap;

    g2e_mul #(.SH(60), .RND(1'b1), .SW(3)) u_sfin (
        .clk, .rst_n, .en,
        .vld_in(vs[6]), .a(ssb[6][SSW-1 -: 64]), .b(ts[6]), .side_in(ssb[6][2:0]),
        .vld_out(s_vld), .p(s_fin), .side_out(s_code)
    );

    g2e_mul #(.SH(60), .RND(1'b1), .SW(SW)) u_hc6 (
        .clk, .rst_n, .en,
        .vld_in(vc[6]), .a(csb[6][CSW-1 -: 64]), .b(tc[6]), .side_in(csb[6][SW-1:0]),
        .vld_out(hc6_vld), .p(hc6), .side_out(hc6_sb)
    );

    g2e_mul #(.SH(60 + LC6), .RND(1'b0), .SW(FSW)) u_dc6 (
        .clk, .rst_n, .en,
        .vld_in(hc6_vld & s_vld), .a(hc6), .b(MC6), .side_in({s_fin, s_code, hc6_sb}),
        .vld_out(fin_vld), .p(qc6), .side_out(fin_sb)
    );

    // Undo the octant swap, then apply the quadrant.
    always_comb
    begin
        sv = fin_sb[FSW-1 -: 64];
        quad = fin_sb[SW+2:SW+1];
        oct_swap = fin_sb[SW];
        cv = ONE_Q60 - qc6;
        o_sin = oct_swap ? cv : sv;
        o_cos = oct_swap ? sv : cv;
        case (quad)
            QUAD_0:
            begin
                sin_mag = o_sin;
                sin_neg = 1'b0;
                cos_mag = o_cos;
                cos_neg = 1'b0;
            end
            QUAD_1:
            begin
                sin_mag = o_cos;
                sin_neg = 1'b0;
                cos_mag = o_sin;
                cos_neg = 1'b1;
            end
            QUAD_2:
            begin
                sin_mag = o_sin;
                sin_neg = 1'b1;
                cos_mag = o_cos;
                cos_neg = 1'b1;
            end
            QUAD_3:
            begin
                sin_mag = o_cos;
                sin_neg = 1'b1;
                cos_mag = o_sin;
                cos_neg = 1'b0;
            end
            default:
            begin
                sin_mag = o_sin;
                sin_neg = 1'b0;
                cos_mag = o_cos;
                cos_neg = 1'b0;
            end
        endcase
    end

    assign vld_out = fin_vld;
    assign side_out = fin_sb[SW-1:0];

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
    import g2e_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] u64_t;
    typedef logic signed [63:0] s64_t;

    // One expected ECEF position.
    typedef struct {
        logic [LEN_W-1:0] x;
        logic [LEN_W-1:0] y;
        logic [LEN_W-1:0] z;
    } ecef_pos_t;

    // Scoreboard: a fixed-point ECEF predictor plus the queue of pending positions.
    class ecef_scoreboard;
        logic [AXIS_W-1:0] axis_mm;
        logic [ECC_W-1:0] ecc_q40;
        ecef_pos_t pending[$];
        int unsigned failures;

        function new();
            axis_mm = AXIS_RESET;
            ecc_q40 = ECC_RESET;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_AXIS)
                axis_mm = val[AXIS_W-1:0];
            else if (idx == REG_ECC)
                ecc_q40 = val[ECC_W-1:0];
        endfunction

        // Unsigned product, rounded half up at the shift, low 64 bits kept.
        function u64_t mul_round(u64_t a, u64_t b, int unsigned sh);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            p = p + (128'd1 << (sh - 1));
            return u64_t'(p >> sh);
        endfunction

        function u64_t magnitude(s64_t v);
            return (v < 0) ? u64_t'(-v) : u64_t'(v);
        endfunction

        // Signed product: magnitude rounded half up, so half away from zero.
        function s64_t smul_round(s64_t a, s64_t b, int unsigned sh);
            u64_t m;
            m = mul_round(magnitude(a), magnitude(b), sh);
            return ((a < 0) != (b < 0)) ? -s64_t'(m) : s64_t'(m);
        endfunction

        // Sine and cosine over one octant by Horner-form Taylor series.
        function void octant_trig(u64_t r, output u64_t s, output u64_t c);
            u64_t x;
            u64_t x2;
            u64_t t;
            x = mul_round(r, PI_Q60, 31);
            x2 = mul_round(x, x, 60);
            t = ONE_Q60;
            for (int i = 0; i < 6; i++)
                t = ONE_Q60 - mul_round(x2, t, 60) / u64_t'(SIN_DEN[i]);
            s = mul_round(x, t, 60);
            t = ONE_Q60;
            for (int i = 0; i < 7; i++)
                t = ONE_Q60 - mul_round(x2, t, 60) / u64_t'(COS_DEN[i]);
            c = t;
        endfunction

        // Full-circle sine and cosine from a binary angle by octant folding.
        function void angle_trig(logic [31:0] ang, output s64_t s, output s64_t c);
            u64_t s0;
            u64_t c0;
            logic [29:0] f;
            f = ang[29:0];
            if (f <= 30'h2000_0000)
                octant_trig(u64_t'(f), s0, c0);
            else
                octant_trig(64'h4000_0000 - u64_t'(f), c0, s0);
            case (ang[31:30])
                2'd0: begin s = s0;  c = c0;  end
                2'd1: begin s = c0;  c = -s0; end
                2'd2: begin s = -s0; c = -c0; end
                default: begin s = -c0; c = s0; end
            endcase
        endfunction

        // Newton iteration for 1/sqrt(w) in Q60.
        function u64_t recip_sqrt(u64_t w);
            u64_t y;
            u64_t y2;
            u64_t wy2;
            y = ONE_Q60 + (ONE_Q60 - w) / 64'd2;
            for (int i = 0; i < 4; i++)
            begin
                y2 = mul_round(y, y, 60);
                wy2 = mul_round(w, y2, 60);
                y = mul_round(y, THREE_Q60 - wy2, 61);
            end
            return y;
        endfunction

        function logic [LEN_W-1:0] clamp_mm(s64_t v);
            s64_t lim;
            lim = s64_t'(OUT_LIMIT);
            if (v > lim)
                v = lim;
            if (v < -lim)
                v = -lim;
            return v[LEN_W-1:0];
        endfunction

        // Note one accepted request and queue the position it should produce.
        function void note_request(logic [31:0] lat, logic [31:0] lon, logic [LEN_W-1:0] hgt);
            s64_t sl, cl, so, co, h, n, rxy, rz, clco, clso;
            u64_t s2, w, y;
            ecef_pos_t e;
            angle_trig(lat, sl, cl);
            angle_trig(lon, so, co);
            h = s64_t'(signed'(hgt));
            s2 = mul_round(magnitude(sl), magnitude(sl), 60);
            w = ONE_Q60 - mul_round(u64_t'(ecc_q40) << 20, s2, 60);
            y = recip_sqrt(w);
            n = s64_t'(mul_round(u64_t'(axis_mm), y, 40));
            rxy = n + (h <<< 20);
            rz = n - s64_t'(mul_round(u64_t'(n), u64_t'(ecc_q40), 40)) + (h <<< 20);
            clco = smul_round(cl, co, 60);
            clso = smul_round(cl, so, 60);
            e.x = clamp_mm(smul_round(rxy, clco, 80));
            e.y = clamp_mm(smul_round(rxy, clso, 80));
            e.z = clamp_mm(smul_round(rz, sl, 80));
            pending.push_back(e);
        endfunction

        // Compare one delivered position with the oldest pending one.
        function void check_result(logic [LEN_W-1:0] x, logic [LEN_W-1:0] y,
                                   logic [LEN_W-1:0] z);
            ecef_pos_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d z=%0d", signed'(x), signed'(y),
                       signed'(z));
                failures++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x)
            begin
                $error("pos_x_mm expected %0d actual %0d", signed'(e.x), signed'(x));
                failures++;
            end
            if (y !== e.y)
            begin
                $error("pos_y_mm expected %0d actual %0d", signed'(e.y), signed'(y));
                failures++;
            end
            if (z !== e.z)
            begin
                $error("pos_z_mm expected %0d actual %0d", signed'(e.z), signed'(z));
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [ANGLE_W-1:0] latitude;
    logic signed [ANGLE_W-1:0] longitude;
    logic signed [LEN_W-1:0] height_mm;
    logic out_valid;
    logic out_ready;
    logic signed [LEN_W-1:0] pos_x_mm;
    logic signed [LEN_W-1:0] pos_y_mm;
    logic signed [LEN_W-1:0] pos_z_mm;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ecef_scoreboard sb = new();
    int unsigned cycle_count = 0;
    bit long_hold_req = 0;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD = 400;

    geodetic_to_ecef_wgs84_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .latitude(latitude), .longitude(longitude), .height_mm(height_mm),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x_mm(pos_x_mm), .pos_y_mm(pos_y_mm), .pos_z_mm(pos_z_mm),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Monitor both handshakes at the rising edge.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && in_valid && in_ready)
            sb.note_request(latitude, longitude, height_mm);
        if (rst_n && out_valid && out_ready)
            sb.check_result(pos_x_mm, pos_y_mm, pos_z_mm);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: stall patterns that rotate, plus a long hold-off on demand.
    initial
    begin
        int unsigned hold_left;
        int unsigned rx_mode;
        hold_left = 0;
        rx_mode = 0;
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left = LONG_HOLD;
            end
            if (cycle_count % 250 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 0;
            end
            else
            begin
                case (rx_mode)
                    0: out_ready = 1;
                    1: out_ready = $urandom_range(0, 1);
                    2: out_ready = ($urandom_range(0, 7) != 0);
                    default: out_ready = (cycle_count % 7) >= 3;
                endcase
            end
        end
    end

    // Present one request and hold it until accepted; returns at a falling edge.
    task automatic offer(logic [31:0] lat, logic [31:0] lon, logic [LEN_W-1:0] hgt);
        in_valid = 1;
        latitude = lat;
        longitude = lon;
        height_mm = hgt;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic go_idle(int unsigned cycles);
        in_valid = 0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (80) @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [31:0] rand_latitude();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    endfunction

    function automatic logic [LEN_W-1:0] rand_height();
        logic [63:0] r;
        int unsigned pick;
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return r[LEN_W-1:0];
        if (pick == 1)
            return LEN_W'(r % 64'd20000000) - LEN_W'(10000000);
        return LEN_W'(r % 64'd100000000001) - LEN_W'(50000000000);
    endfunction

    // Random requests in bursts, mostly separated by random gaps.
    task automatic random_traffic(int unsigned count);
        int unsigned burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 30);
            if (burst > count)
                burst = count;
            count -= burst;
            repeat (burst)
                offer(rand_latitude(), $urandom, rand_height());
            if ($urandom_range(0, 3) != 0)
                go_idle($urandom_range(1, 12));
        end
        in_valid = 0;
    endtask

    // Extremes of every field, octant and quadrant edges, latitude past the poles.
    task automatic directed_traffic();
        offer(32'sh4000_0000, 32'sh8000_0000, 37'sd50000000000);
        offer(-32'sh4000_0000, 32'sh7FFF_FFFF, -37'sd50000000000);
        offer(32'd0, 32'd0, 37'd0);
        offer(32'h2000_0000, 32'h4000_0000, 37'sd1000);
        offer(32'h2000_0001, 32'hC000_0000, -37'sd1000);
        offer(32'h1FFF_FFFF, 32'h2000_0000, 37'sd0);
        offer(-32'sh2000_0000, 32'h2000_0001, 37'sd8848000);
        offer(32'h3FFF_FFFF, 32'h6000_0000, 37'sd0);
        offer(32'h5000_0000, 32'hA000_0000, 37'sd0);
        offer(32'h8000_0000, 32'h1234_5678, 37'sd0);
        offer(32'hFFFF_FFFF, 32'hE000_0000, 37'sd0);
        offer(32'h7FFF_FFFF, 32'h0000_0001, 37'h0F_FFFF_FFFF);
        offer(32'h0000_0001, 32'hFFFF_FFFF, 37'h10_0000_0000);
        offer(32'h1000_0000, 32'h3000_0000, 37'h1F_FFFF_FFFF);
        go_idle(3);
    endtask

    initial
    begin
        in_valid = 0;
        latitude = 0;
        longitude = 0;
        height_mm = 0;
        cfg_we = 0;
        cfg_index = REG_AXIS;
        cfg_data = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // Reset ellipsoid, with a full drain partway through.
        directed_traffic();
        random_traffic(150);
        wait_drained();
        random_traffic(250);

        // Axis of 6000000000 mm and a sphere; long output hold-off while requests keep coming.
        write_reg(REG_AXIS, 36'd6000000000);
        write_reg(REG_ECC, 36'd0);
        long_hold_req = 1;
        directed_traffic();
        random_traffic(300);

        // Axis of 7000000000 mm and the largest e squared the register holds.
        write_reg(REG_AXIS, 36'd7000000000);
        write_reg(REG_ECC, 36'hF_FFFF_FFFF);
        directed_traffic();
        random_traffic(300);

        // Zero axis; writes to indexes past the register list are ignored.
        write_reg(REG_AXIS, 36'd0);
        write_reg(CFG_INDEX_W'(2), 36'h5_5555_5555);
        write_reg(CFG_INDEX_W'(15), 36'hA_AAAA_AAAA);
        directed_traffic();
        random_traffic(200);

        // All-ones axis data, whose upper bits are dropped.
        write_reg(REG_AXIS, 36'hF_FFFF_FFFF);
        write_reg(REG_ECC, 36'd123456789);
        random_traffic(200);

        // Back to WGS-84.
        write_reg(REG_AXIS, 36'(AXIS_RESET));
        write_reg(REG_ECC, 36'(ECC_RESET));
        random_traffic(350);

        wait_drained();
        repeat (100) @(negedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
